// ----- sv/obm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package obm_pkg;

	localparam int unsigned CNT_W = 10;
	localparam int unsigned CFG_DATA_W = 10;
	localparam int unsigned CFG_IDX_W = 3;

	localparam int unsigned READ_SAMPLE_US = 10;
	localparam int unsigned READ_TAIL_US = 50;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_CMD = 1'b1;

	localparam logic [1:0] CMD_RESET = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_W0_LOW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_W0_HIGH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_W1_LOW = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_W1_HIGH = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_READ_LOW = 3'd7;

	typedef struct packed {
		logic [9:0] reset_low_us;
		logic [7:0] presence_wait_us;
		logic [9:0] reset_tail_us;
		logic [7:0] write_zero_low_us;
		logic [7:0] write_zero_high_us;
		logic [7:0] write_one_low_us;
		logic [7:0] write_one_high_us;
		logic [7:0] read_low_us;
	} cfg_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] read_data;
		logic       rejected;
	} res_t;

endpackage
`default_nettype wire

// ----- sv/obm_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
module obm_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [obm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [obm_pkg::CFG_DATA_W-1:0]   cfg_data,
	output obm_pkg::cfg_t                         cfg
);

	obm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_us       <= 10'd500;
			cfg_q.presence_wait_us   <= 8'd70;
			cfg_q.reset_tail_us      <= 10'd430;
			cfg_q.write_zero_low_us  <= 8'd65;
			cfg_q.write_zero_high_us <= 8'd5;
			cfg_q.write_one_low_us   <= 8'd5;
			cfg_q.write_one_high_us  <= 8'd65;
			cfg_q.read_low_us        <= 8'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				obm_pkg::REG_RESET_LOW:     cfg_q.reset_low_us       <= cfg_data;
				obm_pkg::REG_PRESENCE_WAIT: cfg_q.presence_wait_us   <= cfg_data[7:0];
				obm_pkg::REG_RESET_TAIL:    cfg_q.reset_tail_us      <= cfg_data;
				obm_pkg::REG_W0_LOW:        cfg_q.write_zero_low_us  <= cfg_data[7:0];
				obm_pkg::REG_W0_HIGH:       cfg_q.write_zero_high_us <= cfg_data[7:0];
				obm_pkg::REG_W1_LOW:        cfg_q.write_one_low_us   <= cfg_data[7:0];
				obm_pkg::REG_W1_HIGH:       cfg_q.write_one_high_us  <= cfg_data[7:0];
				obm_pkg::REG_READ_LOW:      cfg_q.read_low_us        <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- sv/obm_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
module obm_seq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire obm_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          kind,
	input  wire logic [1:0]    command,
	input  wire logic [7:0]    write_data,
	input  wire logic          line_level,
	input  wire logic          q_ready,
	output logic               res_push,
	output obm_pkg::res_t      res
);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_RESET = 2'd1,
		PH_WRITE = 2'd2,
		PH_READ  = 2'd3
	} phase_t;

	logic       valid_s1;
	logic       kind_s1;
	logic [1:0] command_s1;
	logic [7:0] write_data_s1;
	logic       level_s1;

	phase_t                        phase_q, phase_n;
	logic [1:0]                    sub_q, sub_n;
	logic [obm_pkg::CNT_W-1:0]     tick_q, tick_n, tick_inc, len;
	logic [2:0]                    bit_q, bit_n;
	logic [7:0]                    shift_q, shift_n;
	logic                          pres_q, pres_n;
	logic                          done, pres_out, rej;
	logic [7:0]                    rdata;
	logic [1:0]                    last_sub;
	logic                          accept, go;

	assign go = valid_s1 && q_ready;
	assign in_stall = valid_s1 && !q_ready;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1       <= kind;
			command_s1    <= command;
			write_data_s1 <= write_data;
			level_s1      <= line_level;
		end
	end

	always_comb begin
		unique case (phase_q)
			PH_RESET: begin
				if (sub_q == 2'd0) len = cfg.reset_low_us;
				else if (sub_q == 2'd1) len = {2'b00, cfg.presence_wait_us};
				else len = cfg.reset_tail_us;
			end
			PH_WRITE: begin
				if (sub_q == 2'd0) begin
					len = {2'b00, shift_q[0] ? cfg.write_one_low_us : cfg.write_zero_low_us};
				end else begin
					len = {2'b00, shift_q[0] ? cfg.write_one_high_us : cfg.write_zero_high_us};
				end
			end
			default: begin
				if (sub_q == 2'd0) len = {2'b00, cfg.read_low_us};
				else if (sub_q == 2'd1) len = obm_pkg::CNT_W'(obm_pkg::READ_SAMPLE_US);
				else len = obm_pkg::CNT_W'(obm_pkg::READ_TAIL_US);
			end
		endcase
	end

	assign tick_inc = tick_q + obm_pkg::CNT_W'(1);
	assign last_sub = (phase_q == PH_WRITE) ? 2'd1 : 2'd2;

	always_comb begin
		phase_n  = phase_q;
		sub_n    = sub_q;
		tick_n   = tick_q;
		bit_n    = bit_q;
		shift_n  = shift_q;
		pres_n   = pres_q;
		done     = 1'b0;
		pres_out = 1'b0;
		rdata    = 8'd0;
		rej      = 1'b0;
		if (kind_s1 == obm_pkg::KIND_CMD) begin
			if (phase_q != PH_IDLE) begin
				rej = 1'b1;
			end else if (command_s1 == obm_pkg::CMD_RESET || command_s1 == obm_pkg::CMD_WRITE
					|| command_s1 == obm_pkg::CMD_READ) begin
				if (command_s1 == obm_pkg::CMD_RESET) phase_n = PH_RESET;
				else if (command_s1 == obm_pkg::CMD_WRITE) phase_n = PH_WRITE;
				else phase_n = PH_READ;
				sub_n   = 2'd0;
				tick_n  = '0;
				bit_n   = 3'd0;
				shift_n = (command_s1 == obm_pkg::CMD_WRITE) ? write_data_s1 : 8'd0;
				pres_n  = 1'b0;
			end
		end else if (phase_q != PH_IDLE) begin
			tick_n = tick_inc;
			if (tick_inc >= len) begin
				tick_n = '0;
				if (phase_q == PH_RESET) begin
					if (sub_q == 2'd1) pres_n = !level_s1;
					if (sub_q >= 2'd2) begin
						phase_n  = PH_IDLE;
						sub_n    = 2'd0;
						done     = 1'b1;
						pres_out = pres_n;
					end else begin
						sub_n = sub_q + 2'd1;
					end
				end else begin
					if (phase_q == PH_READ && sub_q == 2'd1) shift_n = {level_s1, shift_q[7:1]};
					if (sub_q < last_sub) begin
						sub_n = sub_q + 2'd1;
					end else begin
						if (phase_q == PH_WRITE) shift_n = {1'b0, shift_q[7:1]};
						sub_n = 2'd0;
						if (bit_q == 3'd7) begin
							if (phase_q == PH_READ) rdata = shift_n;
							phase_n = PH_IDLE;
							bit_n   = 3'd0;
							done    = 1'b1;
						end else begin
							bit_n = bit_q + 3'd1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sub_q   <= 2'd0;
			tick_q  <= '0;
			bit_q   <= 3'd0;
			shift_q <= 8'd0;
			pres_q  <= 1'b0;
		end else if (go) begin
			phase_q <= phase_n;
			sub_q   <= sub_n;
			tick_q  <= tick_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			pres_q  <= pres_n;
		end
	end

	assign res_push      = go;
	assign res.drive_low = (phase_n != PH_IDLE) && (sub_n == 2'd0);
	assign res.busy_res  = (phase_n != PH_IDLE);
	assign res.done_res  = done;
	assign res.presence  = pres_out;
	assign res.read_data = rdata;
	assign res.rejected  = rej;

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> (sub_q == 2'd0 && tick_q == '0 && bit_q == 3'd0))
		else $error("idle with sequence counters not cleared");

	a_reject_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		go && rej |-> !done && phase_n == phase_q)
		else $error("rejected command changed the sequence");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go && done |=> phase_q == PH_IDLE)
		else $error("sequence completed but the master is not idle");

endmodule
`default_nettype wire

// ----- sv/obm_outq.sv -----
`timescale 1ns / 1ps
`default_nettype none
module obm_outq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire obm_pkg::res_t push_res,
	output logic               ready,
	output logic               out_valid,
	input  wire logic          out_stall,
	output obm_pkg::res_t      head
);

	obm_pkg::res_t ent_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	logic          pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop = out_valid && !out_stall;
	assign ready = (cnt_q != 2'd2) || pop;
	assign head = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_res;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ready)
		else $error("beat pushed into a full result queue");

	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(head))
		else $error("stalled result beat changed");

endmodule
`default_nettype wire

// ----- sv/onewire_bus_master.sv -----
`timescale 1ns / 1ps
// A beat is held in the input register, then its result goes into the queue.
// Throughput: one item per cycle unless a full result queue raises in_stall.
// A two-entry result queue lets input beats keep flowing while a result waits.
// Reset (arst_n low, asynchronous) idles the sequencer, empties the queue and
// loads the default bus timings.
`default_nettype none
module onewire_bus_master (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [obm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [obm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            kind,
	input  wire logic [1:0]                      command,
	input  wire logic [7:0]                      write_data,
	input  wire logic                            line_level,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 drive_low,
	output logic                                 busy_res,
	output logic                                 done_res,
	output logic                                 presence,
	output logic [7:0]                           read_data,
	output logic                                 rejected
);

	obm_pkg::cfg_t cfg;
	obm_pkg::res_t res;
	obm_pkg::res_t head;
	logic          res_push;
	logic          q_ready;

	obm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	obm_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.command    (command),
		.write_data (write_data),
		.line_level (line_level),
		.q_ready    (q_ready),
		.res_push   (res_push),
		.res        (res)
	);

	obm_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_res  (res),
		.ready     (q_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign drive_low = head.drive_low;
	assign busy_res  = head.busy_res;
	assign done_res  = head.done_res;
	assign presence  = head.presence;
	assign read_data = head.read_data;
	assign rejected  = head.rejected;

endmodule
`default_nettype wire
